// ----- rtl/pcap_pkg.sv -----
`timescale 1ns / 1ps
package pcap_pkg;

	// Configuration port
	localparam int CFG_W     = 32;
	localparam int REG_IDX_W = 2;
	localparam logic [REG_IDX_W-1:0] REG_COORD_SCALE = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_UNIT_AREA   = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_UNIT_PERIM  = 2'd2;

	// Result width
	localparam int CAP_W = 64;

	// Edge queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QCNT_W      = 2;

	typedef struct packed {
		logic [CFG_W-1:0] coord_scale;
		logic [CFG_W-1:0] area_coef;
		logic [CFG_W-1:0] perim_coef;
	} cfg_t;

	typedef struct packed {
		logic              full;
		logic              empty;
		logic [QCNT_W-1:0] count;
	} queue_stat_t;

endpackage

// ----- rtl/pcap_queue.sv -----
`timescale 1ns / 1ps
module pcap_queue
	import pcap_pkg::*;
#(
	parameter int WIDTH = 152
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output queue_stat_t      stat
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

	logic [WIDTH-1:0]  mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign do_push = push && (count_q != QCNT_W'(QUEUE_DEPTH));
	assign do_pop  = pop && (count_q != '0);

	// Storage is written at the tail only.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign pop_data   = mem_q[rd_ptr_q];
	assign stat.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign stat.empty = (count_q == '0);
	assign stat.count = count_q;

endmodule

// ----- rtl/pcap_front.sv -----
`timescale 1ns / 1ps
module pcap_front
	import pcap_pkg::*;
#(
	parameter int COORD_BITS = 24,
	localparam int DW = COORD_BITS + 1,
	localparam int EW = 6 * DW + 2
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic [COORD_BITS-1:0] in_x,
	input  logic [COORD_BITS-1:0] in_y,
	input  logic                  in_last,
	input  queue_stat_t           q_stat,
	output logic                  in_ready,
	output logic                  q_push,
	output logic [EW-1:0]         q_data
);

	logic signed [COORD_BITS-1:0] first_x_q, first_y_q, prev_x_q, prev_y_q;
	logic                         have_prev_q;
	logic signed [COORD_BITS-1:0] x, y, cx, cy;
	logic signed [DW-1:0]         dx1, dy1, ys1, dx2, dy2, ys2;

	assign x = in_x;
	assign y = in_y;

	// The closing edge runs back to the first vertex, or to itself if this is it.
	assign cx = have_prev_q ? first_x_q : x;
	assign cy = have_prev_q ? first_y_q : y;

	assign dx1 = DW'(x) - DW'(prev_x_q);
	assign dy1 = DW'(y) - DW'(prev_y_q);
	assign ys1 = DW'(y) + DW'(prev_y_q);
	assign dx2 = DW'(cx) - DW'(x);
	assign dy2 = DW'(cy) - DW'(y);
	assign ys2 = DW'(cy) + DW'(y);

	// One queue entry per vertex: the edge into it and, on the last one, the closing edge.
	assign in_ready = !q_stat.full;
	assign q_push   = in_valid && in_ready;
	assign q_data   = {in_last, have_prev_q, ys2, dy2, dx2, ys1, dy1, dx1};

	// Polygon tracking.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_x_q   <= '0;
			first_y_q   <= '0;
			prev_x_q    <= '0;
			prev_y_q    <= '0;
			have_prev_q <= 1'b0;
		end else if (q_push) begin
			if (in_last) begin
				first_x_q   <= '0;
				first_y_q   <= '0;
				prev_x_q    <= '0;
				prev_y_q    <= '0;
				have_prev_q <= 1'b0;
			end else begin
				if (!have_prev_q) begin
					first_x_q <= x;
					first_y_q <= y;
				end
				prev_x_q    <= x;
				prev_y_q    <= y;
				have_prev_q <= 1'b1;
			end
		end
	end

endmodule

// ----- rtl/pcap_back.sv -----
`timescale 1ns / 1ps
module pcap_back
	import pcap_pkg::*;
#(
	parameter int COORD_BITS = 24,
	localparam int DW = COORD_BITS + 1,
	localparam int EW = 6 * DW + 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [EW-1:0]    q_data,
	input  queue_stat_t      q_stat,
	output logic             q_pop,
	input  cfg_t             cfg,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [CAP_W-1:0] out_cap,
	output logic             out_sat
);

	localparam int TW    = 2 * DW;              // area term width
	localparam int SQW   = 2 * COORD_BITS;      // one square
	localparam int SW    = SQW + 1;             // sum of squares
	localparam int RB    = COORD_BITS + 9;      // root bits
	localparam int RADW  = 2 * RB;              // padded radicand
	localparam int IT_W  = $clog2(RB + 1);
	localparam int PW    = 48;                  // perimeter accumulator
	localparam int AW    = 64;                  // doubled area accumulator
	localparam int NLIMB = 5;

	typedef enum logic [9:0] {
		S_IDLE  = 10'b0000000001,
		S_MUL   = 10'b0000000010,
		S_SUM   = 10'b0000000100,
		S_ROOT  = 10'b0000001000,
		S_ACC   = 10'b0000010000,
		S_LOADA = 10'b0000100000,
		S_PASS  = 10'b0001000000,
		S_TAKEA = 10'b0010000000,
		S_TAKEP = 10'b0100000000,
		S_SPARE = 10'b1000000000
	} state_t;

	state_t                  state_q;
	logic signed [DW-1:0]    dx_q, dy_q, ys_q;
	logic signed [DW-1:0]    dx2_q, dy2_q, ys2_q;
	logic                    last_q, close_q;
	logic signed [TW-1:0]    term_q;
	logic [SQW-1:0]          sqx_q, sqy_q;
	logic [RADW-1:0]         rad_q;
	logic [RB+1:0]           rem_q;
	logic [RB-1:0]           root_q;
	logic [IT_W-1:0]         iter_q;
	logic signed [AW-1:0]    area_q;
	logic [PW-1:0]           perim_q;
	logic                    ovf_q;
	logic [31:0]             w_q [NLIMB];
	logic [2:0]              li_q;
	logic [2:0]              pass_q;
	logic [31:0]             carry_q;
	logic [CAP_W-1:0]        acap_q;
	logic                    sa_q;
	logic                    out_valid_q;
	logic [CAP_W-1:0]        out_cap_q;
	logic                    out_sat_q;

	// Entry fields
	logic signed [DW-1:0] e_dx1, e_dy1, e_ys1, e_dx2, e_dy2, e_ys2;
	logic                 e_has1, e_last;
	assign {e_last, e_has1, e_ys2, e_dy2, e_dx2, e_ys1, e_dy1, e_dx1} = q_data;

	// Magnitudes of the edge deltas fit in the coordinate width.
	logic signed [DW-1:0]   ndx, ndy;
	logic [COORD_BITS-1:0]  ax, ay;
	assign ndx = -dx_q;
	assign ndy = -dy_q;
	assign ax  = dx_q[DW-1] ? ndx[COORD_BITS-1:0] : dx_q[COORD_BITS-1:0];
	assign ay  = dy_q[DW-1] ? ndy[COORD_BITS-1:0] : dy_q[COORD_BITS-1:0];

	// One restoring square-root step.
	logic [RB+1:0] rem_sh, trial;
	logic          take_bit;
	assign rem_sh   = {rem_q[RB-1:0], rad_q[RADW-1 -: 2]};
	assign trial    = {root_q, 2'b01};
	assign take_bit = (rem_sh >= trial);

	// Saturating accumulation of one edge.
	logic signed [AW:0] area_sum;
	logic [PW:0]        perim_sum;
	logic               area_ovf;
	assign area_sum  = {area_q[AW-1], area_q} + (AW + 1)'(term_q);
	assign perim_sum = {1'b0, perim_q} + (PW + 1)'(root_q);
	assign area_ovf  = (area_sum[AW] != area_sum[AW-1]);

	// Multiply passes of the result: three for the area, two for the perimeter.
	logic [2:0]  n_sel;
	logic [31:0] f_sel;
	always_comb begin
		unique case (pass_q)
			3'd0:    begin n_sel = 3'd2; f_sel = cfg.coord_scale; end
			3'd1:    begin n_sel = 3'd3; f_sel = cfg.coord_scale; end
			3'd2:    begin n_sel = 3'd4; f_sel = cfg.area_coef;   end
			3'd3:    begin n_sel = 3'd2; f_sel = cfg.coord_scale; end
			3'd4:    begin n_sel = 3'd3; f_sel = cfg.perim_coef;  end
			default: begin n_sel = 3'd2; f_sel = '0;              end
		endcase
	end

	logic [63:0]          limb_prod;
	logic [32*NLIMB-1:0]  w_flat;
	logic [AW-1:0]        mag;
	logic [CAP_W:0]       cap_sum;
	logic [CAP_W-1:0]     pcap;
	logic                 sp;
	assign limb_prod = 64'(w_q[li_q]) * 64'(f_sel) + {32'b0, carry_q};
	assign w_flat    = {w_q[4], w_q[3], w_q[2], w_q[1], w_q[0]};
	assign mag       = area_q[AW-1] ? AW'(-area_q) : AW'(area_q);
	assign sp        = |w_flat[159:112];
	assign pcap      = sp ? '1 : w_flat[111:48];
	assign cap_sum   = {1'b0, acap_q} + {1'b0, pcap};

	assign q_pop = (state_q == S_IDLE) && !q_stat.empty;

	// The result register loads once it is free.
	logic out_load;
	assign out_load = (state_q == S_TAKEP) && (!out_valid_q || out_ready);

	// Per-limb working registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_LOADA: begin
				w_q[0] <= mag[31:0];
				w_q[1] <= mag[63:32];
				w_q[2] <= '0;
				w_q[3] <= '0;
				w_q[4] <= '0;
			end
			S_TAKEA: begin
				w_q[0] <= {8'b0, perim_q[23:0]} | (32'(perim_q[31:24]) << 24);
				w_q[1] <= 32'(perim_q[PW-1:32]);
				w_q[2] <= '0;
				w_q[3] <= '0;
				w_q[4] <= '0;
			end
			S_PASS: begin
				if (li_q < n_sel) begin
					w_q[li_q] <= limb_prod[31:0];
				end else begin
					w_q[n_sel] <= carry_q;
				end
			end
			default: begin
			end
		endcase
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			dx_q        <= '0;
			dy_q        <= '0;
			ys_q        <= '0;
			dx2_q       <= '0;
			dy2_q       <= '0;
			ys2_q       <= '0;
			last_q      <= 1'b0;
			close_q     <= 1'b0;
			term_q      <= '0;
			sqx_q       <= '0;
			sqy_q       <= '0;
			rad_q       <= '0;
			rem_q       <= '0;
			root_q      <= '0;
			iter_q      <= '0;
			area_q      <= '0;
			perim_q     <= '0;
			ovf_q       <= 1'b0;
			li_q        <= '0;
			pass_q      <= '0;
			carry_q     <= '0;
			acap_q      <= '0;
			sa_q        <= 1'b0;
			out_valid_q <= 1'b0;
			out_cap_q   <= '0;
			out_sat_q   <= 1'b0;
		end else begin
			if (out_ready && !out_load) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (!q_stat.empty) begin
						dx2_q   <= e_dx2;
						dy2_q   <= e_dy2;
						ys2_q   <= e_ys2;
						last_q  <= e_last;
						if (e_has1) begin
							dx_q    <= e_dx1;
							dy_q    <= e_dy1;
							ys_q    <= e_ys1;
							close_q <= 1'b0;
							state_q <= S_MUL;
						end else if (e_last) begin
							dx_q    <= e_dx2;
							dy_q    <= e_dy2;
							ys_q    <= e_ys2;
							close_q <= 1'b1;
							state_q <= S_MUL;
						end
					end
				end
				S_MUL: begin
					term_q  <= TW'(dx_q * ys_q);
					sqx_q   <= SQW'(ax * ax);
					sqy_q   <= SQW'(ay * ay);
					state_q <= S_SUM;
				end
				S_SUM: begin
					rad_q   <= {1'b0, SW'(sqx_q) + SW'(sqy_q), 16'b0};
					rem_q   <= '0;
					root_q  <= '0;
					iter_q  <= IT_W'(RB);
					state_q <= S_ROOT;
				end
				S_ROOT: begin
					rad_q  <= {rad_q[RADW-3:0], 2'b00};
					rem_q  <= take_bit ? rem_sh - trial : rem_sh;
					root_q <= {root_q[RB-2:0], take_bit};
					iter_q <= iter_q - 1'b1;
					if (iter_q == IT_W'(1)) begin
						state_q <= S_ACC;
					end
				end
				S_ACC: begin
					if (area_ovf) begin
						area_q <= area_sum[AW] ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}};
					end else begin
						area_q <= area_sum[AW-1:0];
					end
					if (perim_sum[PW]) begin
						perim_q <= '1;
					end else begin
						perim_q <= perim_sum[PW-1:0];
					end
					if (area_ovf || perim_sum[PW]) begin
						ovf_q <= 1'b1;
					end
					if (close_q) begin
						state_q <= S_LOADA;
					end else if (last_q) begin
						dx_q    <= dx2_q;
						dy_q    <= dy2_q;
						ys_q    <= ys2_q;
						close_q <= 1'b1;
						state_q <= S_MUL;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_LOADA: begin
					li_q    <= '0;
					pass_q  <= '0;
					carry_q <= '0;
					state_q <= S_PASS;
				end
				S_PASS: begin
					if (li_q < n_sel) begin
						carry_q <= limb_prod[63:32];
						li_q    <= li_q + 1'b1;
					end else begin
						carry_q <= '0;
						li_q    <= '0;
						if (pass_q == 3'd2) begin
							state_q <= S_TAKEA;
						end else if (pass_q == 3'd4) begin
							state_q <= S_TAKEP;
						end else begin
							pass_q <= pass_q + 1'b1;
						end
					end
				end
				S_TAKEA: begin
					sa_q    <= |w_flat[159:129];
					acap_q  <= (|w_flat[159:129]) ? '1 : w_flat[128:65];
					pass_q  <= 3'd3;
					state_q <= S_PASS;
				end
				S_TAKEP: begin
					// Wait for the output register to be free.
					if (out_load) begin
						out_valid_q <= 1'b1;
						out_cap_q   <= cap_sum[CAP_W] ? '1 : cap_sum[CAP_W-1:0];
						out_sat_q   <= ovf_q || sa_q || sp || cap_sum[CAP_W];
						area_q      <= '0;
						perim_q     <= '0;
						ovf_q       <= 1'b0;
						close_q     <= 1'b0;
						last_q      <= 1'b0;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_cap   = out_cap_q;
	assign out_sat   = out_sat_q;

endmodule

// ----- rtl/polygon_capacitance_accumulator_core.sv -----
`timescale 1ns / 1ps
// Channel   | Signals                          | Content
// ----------+----------------------------------+----------------------------------------
// vertex in | s_tvalid s_tready s_tdata s_tlast | x, y coordinates; tlast = last vertex
// result    | m_tvalid m_tready m_tdata m_tuser | capacitance; tuser = saturated
// config    | cfg_we cfg_index cfg_data        | coord_scale, area and perimeter coefficients
//
// Each edge runs in the back end through S_MUL, S_SUM, S_ROOT and S_ACC, with a
// bit-per-cycle square root in S_ROOT; a last vertex also runs the closing edge, then
// limb-serial 32x32 multiplication passes to form the result.
// Asynchronous active-low reset clears all control state and restores the registers.
// A two-entry edge queue lets vertex intake continue while the back end works or the
// result waits; s_tready falls only when that queue is full.
module polygon_capacitance_accumulator_core
	import pcap_pkg::*;
#(
	parameter int COORD_BITS = 24,
	localparam int IN_W = ((2 * COORD_BITS + 7) / 8) * 8,
	localparam int DW   = COORD_BITS + 1,
	localparam int EW   = 6 * DW + 2
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [IN_W-1:0]      s_tdata,   // vertex_x, vertex_y
	input  logic                 s_tlast,   // last_vertex
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [CAP_W-1:0]     m_tdata,   // capacitance
	output logic                 m_tuser,   // saturated
	input  logic                 cfg_we,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	cfg_t        cfg_q;
	queue_stat_t q_stat;
	logic        q_push, q_pop;
	logic [EW-1:0] push_data, pop_data;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.coord_scale <= 32'h0100_0000;
			cfg_q.area_coef   <= '0;
			cfg_q.perim_coef  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_COORD_SCALE: cfg_q.coord_scale <= cfg_data;
				REG_UNIT_AREA:   cfg_q.area_coef   <= cfg_data;
				REG_UNIT_PERIM:  cfg_q.perim_coef  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	pcap_front #(.COORD_BITS(COORD_BITS)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_x     (s_tdata[COORD_BITS-1:0]),
		.in_y     (s_tdata[2*COORD_BITS-1:COORD_BITS]),
		.in_last  (s_tlast),
		.q_stat   (q_stat),
		.in_ready (s_tready),
		.q_push   (q_push),
		.q_data   (push_data)
	);

	pcap_queue #(.WIDTH(EW)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (push_data),
		.pop       (q_pop),
		.pop_data  (pop_data),
		.stat      (q_stat)
	);

	pcap_back #(.COORD_BITS(COORD_BITS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_data    (pop_data),
		.q_stat    (q_stat),
		.q_pop     (q_pop),
		.cfg       (cfg_q),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_cap   (m_tdata),
		.out_sat   (m_tuser)
	);

	// The queue never holds more entries than it has.
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.count <= QCNT_W'(QUEUE_DEPTH))
		else $error("edge queue overfilled");

	// An accepted vertex always finds room in the queue.
	a_accept_room: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |-> (q_stat.count < QCNT_W'(QUEUE_DEPTH)))
		else $error("vertex accepted with queue full");

	// A pop and an empty queue never meet.
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_stat.empty)
		else $error("pop from empty queue");

endmodule

// ----- sim/polygon_capacitance_checker.sv -----
`timescale 1ns / 1ps
// Watches the vertex, result and configuration channels. It works out the expected
// capacitance of each polygon and compares it with each result item.
module polygon_capacitance_checker
	import pcap_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	input  logic                 s_tready,
	input  logic [47:0]          s_tdata,   // vertex_x, vertex_y
	input  logic                 s_tlast,   // last_vertex
	input  logic                 m_tvalid,
	input  logic                 m_tready,
	input  logic [CAP_W-1:0]     m_tdata,   // capacitance
	input  logic                 m_tuser,   // saturated
	input  logic                 cfg_we,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	output int                   failures,
	output int                   pending
);

	typedef struct packed {
		logic [CAP_W-1:0] capacitance;
		logic             saturated;
	} cap_result_t;

	localparam logic [47:0] PERIM_LIMIT = '1;

	// Shadow copy of the registers.
	logic [CFG_W-1:0] scale, area_coef, perim_coef;

	// Shadow copy of the polygon being summed.
	longint      start_x, start_y, last_x, last_y;
	logic        open_poly;
	longint      area2_sum;
	logic [47:0] perim_sum;
	logic        ovf_seen;

	cap_result_t expected_caps[$];

	assign pending = expected_caps.size();

	// floor(sqrt(s * 65536)), bit by bit.
	function automatic logic [47:0] edge_length(logic [63:0] s);
		logic [127:0] v;
		logic [127:0] c2;
		logic [63:0]  r;
		logic [63:0]  c;
		v = {64'b0, s} << 16;
		r = '0;
		for (int b = 40; b >= 0; b--) begin
			c  = r | (64'd1 << b);
			c2 = {64'b0, c} * {64'b0, c};
			if (c2 <= v)
				r = c;
		end
		return r[47:0];
	endfunction

	function automatic longint sign_coord(logic [23:0] v);
		return longint'($signed(v));
	endfunction

	// Adds one edge to the running area and perimeter, saturating.
	task automatic sum_edge(longint x0, longint y0, longint x1, longint y1);
		longint      dx;
		longint      dy;
		longint      term;
		logic [63:0] ax;
		logic [63:0] ay;
		logic [47:0] len;
		dx   = x1 - x0;
		dy   = y1 - y0;
		term = dx * (y1 + y0);
		ax   = dx < 0 ? -dx : dx;
		ay   = dy < 0 ? -dy : dy;
		len  = edge_length(ax * ax + ay * ay);
		if (term > 0 && area2_sum > 64'sh7FFF_FFFF_FFFF_FFFF - term) begin
			area2_sum = 64'sh7FFF_FFFF_FFFF_FFFF;
			ovf_seen  = 1'b1;
		end else if (term < 0 && area2_sum < -64'sh7FFF_FFFF_FFFF_FFFF - 1 - term) begin
			area2_sum = -64'sh7FFF_FFFF_FFFF_FFFF - 1;
			ovf_seen  = 1'b1;
		end else begin
			area2_sum = area2_sum + term;
		end
		if (len > PERIM_LIMIT - perim_sum) begin
			perim_sum = PERIM_LIMIT;
			ovf_seen  = 1'b1;
		end else begin
			perim_sum = perim_sum + len;
		end
	endtask

	// Scales area and perimeter and adds the two capacitance terms.
	function automatic cap_result_t polygon_capacitance();
		cap_result_t  res;
		logic [63:0]  mag;
		logic [191:0] pa;
		logic [127:0] pp;
		logic [63:0]  acap;
		logic [63:0]  pcap;
		logic [64:0]  total;
		res.saturated = ovf_seen;
		mag  = area2_sum < 0 ? -area2_sum : area2_sum;
		pa   = {128'b0, mag} * {160'b0, scale};
		pa   = pa * {160'b0, scale};
		pa   = pa * {160'b0, area_coef};
		if (pa[191:129] != 0) begin
			acap = '1;
			res.saturated = 1'b1;
		end else begin
			acap = pa[128:65];
		end
		pp   = {80'b0, perim_sum} * {96'b0, scale};
		pp   = pp * {96'b0, perim_coef};
		if (pp[127:112] != 0) begin
			pcap = '1;
			res.saturated = 1'b1;
		end else begin
			pcap = pp[111:48];
		end
		total = {1'b0, acap} + {1'b0, pcap};
		if (total[64]) begin
			res.capacitance = '1;
			res.saturated   = 1'b1;
		end else begin
			res.capacitance = total[63:0];
		end
		return res;
	endfunction

	task automatic clear_polygon();
		start_x   = 0;
		start_y   = 0;
		last_x    = 0;
		last_y    = 0;
		open_poly = 1'b0;
		area2_sum = 0;
		perim_sum = '0;
		ovf_seen  = 1'b0;
	endtask

	// Register shadow, vertex intake and result comparison.
	always @(posedge clk or negedge arst_n) begin
		longint      x;
		longint      y;
		cap_result_t exp_res;
		if (!arst_n) begin
			scale      <= 32'h0100_0000;
			area_coef  <= '0;
			perim_coef <= '0;
			failures   <= 0;
			clear_polygon();
			expected_caps.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_COORD_SCALE: scale      <= cfg_data;
					REG_UNIT_AREA:   area_coef  <= cfg_data;
					REG_UNIT_PERIM:  perim_coef <= cfg_data;
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				x = sign_coord(s_tdata[23:0]);
				y = sign_coord(s_tdata[47:24]);
				if (!open_poly) begin
					start_x   = x;
					start_y   = y;
					open_poly = 1'b1;
				end else begin
					sum_edge(last_x, last_y, x, y);
				end
				last_x = x;
				last_y = y;
				if (s_tlast) begin
					sum_edge(last_x, last_y, start_x, start_y);
					expected_caps.push_back(polygon_capacitance());
					clear_polygon();
				end
			end
			if (m_tvalid && m_tready) begin
				if (expected_caps.size() == 0) begin
					if (failures < 10)
						$display("unexpected result item: cap=%h sat=%b", m_tdata, m_tuser);
					failures <= failures + 1;
				end else begin
					exp_res = expected_caps.pop_front();
					if (m_tdata !== exp_res.capacitance || m_tuser !== exp_res.saturated) begin
						if (failures < 10)
							$display("result mismatch: expected cap=%h sat=%b, got cap=%h sat=%b",
								exp_res.capacitance, exp_res.saturated, m_tdata, m_tuser);
						failures <= failures + 1;
					end
				end
			end
		end
	end

endmodule

// ----- sim/polygon_capacitance_accumulator_core_test.sv -----
`timescale 1ns / 1ps
// Drives polygons and register settings into the core and gives the verdict.
module polygon_capacitance_accumulator_core_test;
	import pcap_pkg::*;

	localparam logic [REG_IDX_W-1:0] REG_SPARE = 2'd3;
	localparam int STALL_LIMIT = 5000;
	localparam int MAX_C = 8388607;
	localparam int MIN_C = -8388608;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [47:0]          s_tdata = '0;   // vertex_x, vertex_y
	logic                 s_tlast = 1'b0; // last_vertex
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [CAP_W-1:0]     m_tdata;        // capacitance
	logic                 m_tuser;        // saturated
	logic                 cfg_we = 1'b0;
	logic [REG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;
	int                   failures;
	int                   pending;
	logic                 calm = 1'b0;
	int                   idle_cycles = 0;

	always #5 clk = ~clk;

	polygon_capacitance_accumulator_core dut (.*);

	polygon_capacitance_checker checker_i (.*);

	// Result side stalls at random except in the calm stretch.
	always @(negedge clk)
		m_tready <= calm || ($urandom_range(99) >= 8);

	// Ends the run when nothing moves for too long.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("polygon_capacitance_accumulator_core_test: FAIL");
			$finish;
		end
	end

	task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	task automatic set_regs(logic [31:0] sc, logic [31:0] ac, logic [31:0] pc);
		write_reg(REG_COORD_SCALE, sc);
		write_reg(REG_UNIT_AREA, ac);
		write_reg(REG_UNIT_PERIM, pc);
	endtask

	// Lets the block drain before the registers change.
	task automatic drain();
		while (pending != 0)
			@(negedge clk);
		repeat (150) @(negedge clk);
	endtask

	// Offers one vertex item and holds it until it is taken.
	task automatic send_vertex(int x, int y, logic last);
		@(negedge clk);
		if (!calm && $urandom_range(99) < 8) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(5, 1)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {y[23:0], x[23:0]};
		s_tlast  <= last;
		while (!s_tready)
			@(negedge clk);
		@(posedge clk);
	endtask

	task automatic release_input();
		@(negedge clk);
		s_tvalid <= 1'b0;
	endtask

	function automatic int pick_coord(int mode);
		case (mode)
			0: return $urandom_range(2000) - 1000;
			1: return $urandom_range(3) == 0 ? MAX_C : MIN_C + $urandom_range(3);
			default: return int'($signed(24'($urandom)));
		endcase
	endfunction

	// Random polygon of mostly few vertices.
	task automatic random_polygon(output int n);
		int mode;
		mode = $urandom_range(2);
		n = $urandom_range(9) == 0 ? $urandom_range(40, 7) : $urandom_range(6, 1);
		for (int i = 0; i < n; i++)
			send_vertex(pick_coord(mode), pick_coord(mode), i == n - 1);
	endtask

	initial begin
		int sent;
		int n;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		// Reset settings: every result is zero.
		send_vertex(10, 10, 1'b0);
		send_vertex(20, 10, 1'b0);
		send_vertex(20, 30, 1'b1);
		release_input();
		drain();

		// Directed shapes at unit scale.
		set_regs(32'h0100_0000, 32'h8000_0000, 32'h4000_0000);
		write_reg(REG_SPARE, 32'hFFFF_FFFF);
		send_vertex(5, -7, 1'b1);                       // single vertex
		send_vertex(0, 0, 1'b0);                        // square
		send_vertex(100, 0, 1'b0);
		send_vertex(100, 100, 1'b0);
		send_vertex(0, 100, 1'b1);
		send_vertex(0, 0, 1'b0);                        // square closed again
		send_vertex(100, 0, 1'b0);
		send_vertex(100, 100, 1'b0);
		send_vertex(0, 100, 1'b0);
		send_vertex(0, 0, 1'b1);
		send_vertex(0, 0, 1'b0);                        // clockwise triangle
		send_vertex(0, 50, 1'b0);
		send_vertex(37, 0, 1'b1);
		send_vertex(MIN_C, MIN_C, 1'b0);                // full range triangle
		send_vertex(MAX_C, MIN_C, 1'b0);
		send_vertex(MAX_C, MAX_C, 1'b1);
		send_vertex(-3, -3, 1'b0);                      // collinear
		send_vertex(4, 4, 1'b1);
		release_input();
		drain();

		// Largest settings drive the result into saturation.
		set_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_vertex(MIN_C, MAX_C, 1'b0);
		send_vertex(MAX_C, MIN_C, 1'b0);
		send_vertex(MAX_C, MAX_C, 1'b1);
		send_vertex(1, 1, 1'b0);
		send_vertex(2, 1, 1'b1);
		release_input();
		drain();

		// Random phases, each under its own register setting.
		for (int phase = 0; phase < 8; phase++) begin
			case (phase)
				0: set_regs(32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
				1: set_regs(32'h0100_0000, $urandom, $urandom);
				4: set_regs(32'hFFFF_FFFF, $urandom, $urandom);
				5: set_regs(32'h0000_0001, 32'h0000_0001, 32'hFFFF_FFFF);
				default: set_regs($urandom, $urandom, $urandom);
			endcase
			calm = (phase == 3);
			sent = 0;
			while (sent < 100) begin
				random_polygon(n);
				sent += n;
				if (phase == 2) begin
					release_input();
					while (pending != 0)
						@(negedge clk);
				end
			end
			release_input();
			calm = 1'b0;
			drain();
		end

		if (failures == 0)
			$display("polygon_capacitance_accumulator_core_test: PASS");
		else
			$display("polygon_capacitance_accumulator_core_test: FAIL");
		$finish;
	end

endmodule
